// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: hw/rtl/wha_pkg.sv
// ----------------------------------------------------------------------------
// wha_pkg
// Widths, codes and shared types of the weighted histogram accumulator.
// ----------------------------------------------------------------------------
package wha_pkg;

	localparam int NBINS_DEF  = 300;

	localparam int REQ_W      = 2;
	localparam int VALUE_W    = 32;
	localparam int WEIGHT_W   = 24;
	localparam int BIN_W      = 9;
	localparam int WSUM_W     = 48;
	localparam int SSUM_W     = 64;
	localparam int SQ_W       = 2 * WEIGHT_W;
	localparam int PTS_W      = 32;
	localparam int SCALE_W    = 32;
	localparam int PROD_W     = VALUE_W + SCALE_W;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_FILL  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE  = 2'd2;

	// control from the sequencer to the bin store
	typedef struct packed {
		logic rd;     // read the addressed entry
		logic acc;    // write back the accumulated entry
		logic clear;  // start a clearing pass
	} store_ctl_t;

endpackage

// File: hw/rtl/weighted_histogram_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator
// One weighted histogram with per-bin weight sums and squared-weight sums.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   request   req_valid / req_ready  req_type sample_value sample_weight
//                                    read_bin
//   response  rsp_valid / rsp_ready  in_range bin_number weight_total
//                                    square_total point_total
//   config    cfg_we                 cfg_index cfg_data
//
// A fill beat goes through the prepare, multiply, read and write-back steps
// before the next acceptance, skipping the read when the value is out of
// range; a read goes through the read and response steps, and an unused
// code is dropped in idle. The bin memory has one read-modify-write port,
// and fills walk through their steps one at a time. A clear beat runs a
// clearing pass over all NBINS entries of the memory, then a response step.
// After reset the same pass runs before the first request.
// A waiting response holds only the write-back step; the next request is
// accepted as soon as the response register is loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_histogram_accumulator #(
	parameter int NBINS = wha_pkg::NBINS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [wha_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wha_pkg::CFG_DATA_W-1:0]        cfg_data,
	// request channel
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  logic [wha_pkg::REQ_W-1:0]             req_type,
	input  logic signed [wha_pkg::VALUE_W-1:0]    sample_value,
	input  logic signed [wha_pkg::WEIGHT_W-1:0]   sample_weight,
	input  logic [wha_pkg::BIN_W-1:0]             read_bin,
	// response channel
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output logic                                  in_range,
	output logic [wha_pkg::BIN_W-1:0]             bin_number,
	output logic signed [wha_pkg::WSUM_W-1:0]     weight_total,
	output logic [wha_pkg::SSUM_W-1:0]            square_total,
	output logic [wha_pkg::PTS_W-1:0]             point_total
);
	import wha_pkg::*;

	localparam int AW = $clog2(NBINS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_RD,
		S_RES,
		S_CLR
	} state_t;

	state_t                     state_q;

	// configuration registers
	logic signed [VALUE_W-1:0]  low_q;
	logic signed [VALUE_W-1:0]  high_q;
	logic [SCALE_W-1:0]         scale_q;

	// request held for the duration of its work
	logic [REQ_W-1:0]           op_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic [BIN_W-1:0]           read_bin_q;

	// fill datapath
	logic                       inr_q;
	logic [VALUE_W-1:0]         diff_q;
	logic [PROD_W-1:0]          prod_q;
	logic [SQ_W-1:0]            sq_q;
	logic signed [SQ_W-1:0]     sq_full;
	logic [AW-1:0]              addr_q;
	logic                       rd_ok_q;
	logic [PTS_W-1:0]           pts_q;

	// response register
	logic                       rsp_valid_q;
	logic                       in_range_q;
	logic [BIN_W-1:0]           bin_number_q;
	logic signed [WSUM_W-1:0]   weight_total_q;
	logic [SSUM_W-1:0]          square_total_q;
	logic [PTS_W-1:0]           point_total_q;

	// payload about to be loaded into the response register
	logic                       nxt_in_range;
	logic [BIN_W-1:0]           nxt_bin;
	logic signed [WSUM_W-1:0]   nxt_wsum;
	logic [SSUM_W-1:0]          nxt_ssum;

	// store interface
	store_ctl_t                 ctl;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              store_addr;
	logic                       busy;
	logic                       rd_ok;
	logic signed [WSUM_W-1:0]   old_wsum;
	logic [SSUM_W-1:0]          old_ssum;
	logic signed [WSUM_W-1:0]   new_wsum;
	logic [SSUM_W-1:0]          new_ssum;

	logic                       req_accept;
	logic                       slot_free;
	logic                       rsp_load;
	logic [PROD_W-FRAC_W-1:0]   idx_full;

	assign req_ready  = (state_q == S_IDLE) && !busy;
	assign req_accept = req_valid && req_ready;
	// response register is empty or being drained this cycle
	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load   = (state_q == S_RES) && slot_free;

	assign rsp_valid    = rsp_valid_q;
	assign in_range     = in_range_q;
	assign bin_number   = bin_number_q;
	assign weight_total = weight_total_q;
	assign square_total = square_total_q;
	assign point_total  = point_total_q;

	// Bin index: drop the fraction of diff * scale and clamp to the last bin.
	assign idx_full = prod_q[PROD_W-1:FRAC_W];
	assign rd_ok    = 32'(read_bin_q) < 32'(NBINS);
	assign sq_full  = SQ_W'(weight_q) * SQ_W'(weight_q);

	always_comb begin
		if (op_q == REQ_FILL) begin
			if (idx_full > (PROD_W-FRAC_W)'(NBINS - 1)) begin
				rd_addr = AW'(NBINS - 1);
			end else begin
				rd_addr = idx_full[AW-1:0];
			end
		end else begin
			rd_addr = AW'(read_bin_q);
		end
	end

	// Only the read step drives a fresh address; write-back reuses the held one.
	assign store_addr = (state_q == S_RD) ? rd_addr : addr_q;

	always_comb begin
		ctl       = '0;
		ctl.clear = req_accept && (req_type == REQ_CLEAR);
		ctl.rd    = (state_q == S_RD) && ((op_q == REQ_FILL) || rd_ok);
		ctl.acc   = (state_q == S_RES) && slot_free && (op_q == REQ_FILL) && inr_q;
	end

	wha_bin_store #(
		.NBINS (NBINS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.addr     (store_addr),
		.weight   (weight_q),
		.square   (sq_q),
		.busy     (busy),
		.old_wsum (old_wsum),
		.old_ssum (old_ssum),
		.new_wsum (new_wsum),
		.new_ssum (new_ssum)
	);

	// Configuration writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			high_q  <= '0;
			scale_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:  low_q   <= signed'(cfg_data);
				REG_RANGE_HIGH: high_q  <= signed'(cfg_data);
				REG_BIN_SCALE:  scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Response payload: zero sums unless a fill hit or a read is valid; a read always echoes its bin.
	always_comb begin
		nxt_in_range = 1'b0;
		nxt_bin      = '0;
		nxt_wsum     = '0;
		nxt_ssum     = '0;
		case (op_q)
			REQ_FILL: begin
				if (inr_q) begin
					nxt_in_range = 1'b1;
					nxt_bin      = BIN_W'(addr_q);
					nxt_wsum     = new_wsum;
					nxt_ssum     = new_ssum;
				end
			end
			REQ_READ: begin
				nxt_bin = read_bin_q;
				if (rd_ok_q) begin
					nxt_wsum = old_wsum;
					nxt_ssum = old_ssum;
				end
			end
			default: ;
		endcase
	end

	// Sequencer: one request at a time; fills go through prepare, multiply, read and write-back,
	// reads through read and response, clears through the clearing pass. Holds the point count and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= REQ_FILL;
			pts_q          <= '0;
			rsp_valid_q    <= 1'b0;
			in_range_q     <= 1'b0;
			bin_number_q   <= '0;
			weight_total_q <= '0;
			square_total_q <= '0;
			point_total_q  <= '0;
		end else begin
			// load a fresh response, else drop the one just taken
			if (rsp_load) begin
				rsp_valid_q    <= 1'b1;
				in_range_q     <= nxt_in_range;
				bin_number_q   <= nxt_bin;
				weight_total_q <= nxt_wsum;
				square_total_q <= nxt_ssum;
				point_total_q  <= pts_q;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						op_q <= req_type;
						case (req_type)
							REQ_FILL:  state_q <= S_PREP;
							REQ_READ:  state_q <= S_RD;
							REQ_CLEAR: begin
								pts_q   <= '0;
								state_q <= S_CLR;
							end
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_PREP: begin
					// every fill counts a point, in range or not
					if (pts_q != '1) begin
						pts_q <= pts_q + PTS_W'(1);
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= inr_q ? S_RD : S_RES;
				end
				S_RD: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					if (!busy) begin
						state_q <= S_RES;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req_accept) begin
			value_q    <= sample_value;
			weight_q   <= sample_weight;
			read_bin_q <= read_bin;
		end
		if (state_q == S_PREP) begin
			inr_q  <= (value_q > low_q) && (value_q < high_q);
			diff_q <= VALUE_W'(value_q - low_q);
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(diff_q) * PROD_W'(scale_q);
			sq_q   <= unsigned'(sq_full);
		end
		if (state_q == S_RD) begin
			addr_q  <= rd_addr;
			rd_ok_q <= rd_ok;
		end
	end

	`ASSERT_NEVER(no_acc_in_sweep, ctl.acc && busy, "bin write-back during clearing pass")
	`ASSERT_CLK(pts_step, (pts_q != $past(pts_q)) |-> ((pts_q == $past(pts_q) + PTS_W'(1)) || (pts_q == '0)), "point count moved by other than one")
	`ASSERT_CLK(rsp_bin_bound, (rsp_valid && in_range) |-> (32'(bin_number) < 32'(NBINS)), "filled bin past last bin")

endmodule

// File: hw/rtl/wha_bin_store.sv
// ----------------------------------------------------------------------------
// wha_bin_store
// Bin memory with saturating read-modify-write and a clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wha_bin_store #(
	parameter int NBINS = wha_pkg::NBINS_DEF,
	localparam int AW = $clog2(NBINS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wha_pkg::store_ctl_t                 ctl,
	input  logic [AW-1:0]                       addr,
	input  logic signed [wha_pkg::WEIGHT_W-1:0] weight,
	input  logic [wha_pkg::SQ_W-1:0]            square,
	output logic                                busy,
	output logic signed [wha_pkg::WSUM_W-1:0]   old_wsum,
	output logic [wha_pkg::SSUM_W-1:0]          old_ssum,
	output logic signed [wha_pkg::WSUM_W-1:0]   new_wsum,
	output logic [wha_pkg::SSUM_W-1:0]          new_ssum
);
	import wha_pkg::*;

	typedef struct packed {
		logic [WSUM_W-1:0] wsum;
		logic [SSUM_W-1:0] ssum;
	} entry_t;

	entry_t          mem [NBINS];
	entry_t          rd_q;
	logic            sweep_q;
	logic [AW-1:0]   sweep_addr_q;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic [WSUM_W:0] wsum_ext;
	logic [SSUM_W:0] ssum_ext;

	assign busy     = sweep_q;
	assign old_wsum = signed'(rd_q.wsum);
	assign old_ssum = rd_q.ssum;

	// saturating accumulate of the entry read last
	assign wsum_ext = {rd_q.wsum[WSUM_W-1], rd_q.wsum}
		+ {{(WSUM_W + 1 - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
	assign ssum_ext = {1'b0, rd_q.ssum} + {{(SSUM_W + 1 - SQ_W){1'b0}}, square};

	always_comb begin
		if (wsum_ext[WSUM_W] != wsum_ext[WSUM_W-1]) begin
			new_wsum = wsum_ext[WSUM_W] ? signed'({1'b1, {(WSUM_W-1){1'b0}}})
				: signed'({1'b0, {(WSUM_W-1){1'b1}}});
		end else begin
			new_wsum = signed'(wsum_ext[WSUM_W-1:0]);
		end
		new_ssum = ssum_ext[SSUM_W] ? '1 : ssum_ext[SSUM_W-1:0];
	end

	assign wr_en   = sweep_q || ctl.acc;
	assign wr_addr = sweep_q ? sweep_addr_q : addr;
	assign wr_data = sweep_q ? '0 : entry_t'{wsum: new_wsum, ssum: new_ssum};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_q <= mem[addr];
		end
	end

	// clearing pass: one entry a cycle, started by reset or a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (ctl.clear) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			if (sweep_addr_q == AW'(NBINS - 1)) begin
				sweep_q <= 1'b0;
			end else begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end
		end
	end

	`ASSERT_CLK(sweep_in_bounds, sweep_q |-> (32'(sweep_addr_q) < 32'(NBINS)), "sweep address past last bin")
	`ASSERT_NEVER(rd_acc_excl, ctl.rd && ctl.acc, "read and write-back in the same cycle")

endmodule
